[rtl/bba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, table entry layout and controller/datapath interface
// types for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Geometry
  localparam int MIN_BLOCK_LOG2 = 12;
  localparam int NUM_UNITS      = 1024;
  localparam int UNIT_W         = $clog2(NUM_UNITS);
  localparam int MAX_ORDER      = UNIT_W;
  localparam int ORD_W          = $clog2(MAX_ORDER + 1);
  localparam int ENT_W          = ORD_W + 2;
  localparam int ADDR_W         = 64;
  localparam int SIZE_W         = 32;
  localparam int LOG2_W         = 5;
  localparam int REGION_RESET   = 22;

  // Table entry bit positions
  localparam int E_START = ORD_W + 1;
  localparam int E_FREE  = ORD_W;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 1'd1;

  // Table read address select
  typedef enum logic [1:0] {
    RD_U,
    RD_NEXT,
    RD_BUDDY
  } rd_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    clr_start;
    logic    clr_step;
    rd_sel_e rd_sel;
    logic    scan_adv;
    logic    ord_ld;
    logic    split;
    logic    take;
    logic    merge;
    logic    fset;
    logic    fail;
    logic    publish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cmd_free;
    logic pre_fail;
    logic ent_match;
    logic scan_end;
    logic split_more;
    logic ent_alloc;
    logic merge_more;
    logic buddy_ok;
    logic clr_last;
  } dp_status_t;

endpackage

[rtl/bba_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_table
// Unit table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bba_table (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bba_pkg::UNIT_W-1:0]  waddr_i,
  input  logic [bba_pkg::ENT_W-1:0]   wdata_i,
  input  logic [bba_pkg::UNIT_W-1:0]  raddr_i,
  output logic [bba_pkg::ENT_W-1:0]   rdata_o
);
  import bba_pkg::*;

  logic [ENT_W-1:0] mem_q [NUM_UNITS];
  logic [ENT_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bba_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Configuration registers, request decode, scan/split/merge pointers, unit
// table and result registers.
// ----------------------------------------------------------------------------
module bba_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bba_pkg::ADDR_W-1:0]     cfg_wdata_i,
  input  logic                           command_i,
  input  logic [bba_pkg::SIZE_W-1:0]     request_size_i,
  input  logic [bba_pkg::ADDR_W-1:0]     block_address_i,
  input  bba_pkg::ctrl_cmd_t             cmd_i,
  output bba_pkg::dp_status_t            sts_o,
  output logic [1:0]                     status_o,
  output logic [bba_pkg::ADDR_W-1:0]     granted_address_o,
  output logic [bba_pkg::LOG2_W-1:0]     granted_log2_o
);
  import bba_pkg::*;

  localparam int SZ_N_W = $clog2(SIZE_W + 1);
  localparam int CNT_W  = UNIT_W + 1;

  // Config registers
  logic [ADDR_W-1:0] base_q;
  logic [LOG2_W-1:0] region_q;

  // Request state
  logic              cmd_q, zero_q, big_q, bad_q;
  logic [LOG2_W-1:0] n_q;
  logic [ORD_W-1:0]  need_q, ord_q;
  logic [UNIT_W-1:0] u_q, clr_q;

  // Result and output registers
  logic [1:0]        res_status_q, out_status_q;
  logic [ADDR_W-1:0] res_addr_q, out_addr_q;
  logic [LOG2_W-1:0] res_log2_q, out_log2_q;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      region_q <= LOG2_W'(REGION_RESET);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BASE) begin
        base_q <= cfg_wdata_i;
      end else begin
        region_q <= cfg_wdata_i[LOG2_W-1:0];
      end
    end
  end

  // Effective top order: region log2 clamped to the table span
  logic [LOG2_W-1:0] region_c;
  logic [ORD_W-1:0]  top;
  logic [CNT_W-1:0]  units;
  always_comb begin
    region_c = region_q;
    if (region_q < LOG2_W'(MIN_BLOCK_LOG2)) begin
      region_c = LOG2_W'(MIN_BLOCK_LOG2);
    end else if (region_q > LOG2_W'(MIN_BLOCK_LOG2 + MAX_ORDER)) begin
      region_c = LOG2_W'(MIN_BLOCK_LOG2 + MAX_ORDER);
    end
  end
  assign top   = ORD_W'(region_c - LOG2_W'(MIN_BLOCK_LOG2));
  assign units = CNT_W'(1) << top;

  // Request decode: rounded-up log2 of the size
  logic [SIZE_W-1:0] size_m1;
  logic [SZ_N_W-1:0] n_raw, n_cl;
  always_comb begin
    size_m1 = request_size_i - SIZE_W'(1);
    n_raw   = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size_m1[i]) begin
        n_raw = SZ_N_W'(i + 1);
      end
    end
    if (request_size_i <= SIZE_W'(1)) begin
      n_raw = '0;
    end
    n_cl = (n_raw < SZ_N_W'(MIN_BLOCK_LOG2)) ? SZ_N_W'(MIN_BLOCK_LOG2) : n_raw;
  end

  // Free address decode
  logic [ADDR_W-1:0] off;
  logic [UNIT_W-1:0] off_u, unit_mask;
  logic              off_bad;
  assign off       = block_address_i - base_q;
  assign off_u     = off[MIN_BLOCK_LOG2 +: UNIT_W];
  assign unit_mask = UNIT_W'(units - CNT_W'(1));
  assign off_bad   = (off[ADDR_W-1:MIN_BLOCK_LOG2+UNIT_W] != '0)
                   || ((off_u & ~unit_mask) != '0)
                   || (off[MIN_BLOCK_LOG2-1:0] != '0);

  // Table entry read back
  logic [ENT_W-1:0]  ent;
  logic              e_start, e_free;
  logic [ORD_W-1:0]  e_ord;
  logic [CNT_W-1:0]  step, u_next, obit_w;
  logic [UNIT_W-1:0] obit;
  assign e_start = ent[E_START];
  assign e_free  = ent[E_FREE];
  assign e_ord   = ent[ORD_W-1:0];
  assign step    = e_start ? (CNT_W'(1) << e_ord) : CNT_W'(1);
  assign u_next  = {1'b0, u_q} + step;
  // full-span block size needs one bit more than a unit index
  assign obit_w  = CNT_W'(1) << ord_q;
  assign obit    = obit_w[UNIT_W-1:0];

  // Status to controller
  assign sts_o.cmd_free   = cmd_q;
  assign sts_o.pre_fail   = cmd_q ? bad_q : (zero_q || big_q);
  assign sts_o.ent_match  = e_start && e_free && (e_ord >= need_q);
  assign sts_o.scan_end   = (u_next >= units);
  assign sts_o.split_more = (ord_q > need_q);
  assign sts_o.ent_alloc  = e_start && !e_free;
  assign sts_o.merge_more = (ord_q < top);
  assign sts_o.buddy_ok   = e_start && e_free && (e_ord == ord_q);
  assign sts_o.clr_last   = (clr_q == UNIT_W'(NUM_UNITS - 1));

  // Table ports
  logic              t_we;
  logic [UNIT_W-1:0] t_waddr, t_raddr;
  logic [ENT_W-1:0]  t_wdata;
  always_comb begin
    t_we    = 1'b1;
    t_waddr = u_q;
    t_wdata = '0;
    if (cmd_i.clr_step) begin
      t_waddr = clr_q;
      t_wdata = (clr_q == '0) ? {2'b11, top} : '0;
    end else if (cmd_i.split) begin
      t_waddr = u_q + obit_w[UNIT_W:1];
      t_wdata = {2'b11, ord_q - ORD_W'(1)};
    end else if (cmd_i.take) begin
      t_wdata = {2'b10, ord_q};
    end else if (cmd_i.merge) begin
      t_waddr = u_q | obit;
    end else if (cmd_i.fset) begin
      t_wdata = {2'b11, ord_q};
    end else begin
      t_we = 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_NEXT:  t_raddr = u_next[UNIT_W-1:0];
      RD_BUDDY: t_raddr = u_q ^ obit;
      default:  t_raddr = u_q;
    endcase
  end

  bba_table u_table (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (ent)
  );

  // Clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + UNIT_W'(1);
    end
  end

  // Request capture, pointers and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      zero_q <= (request_size_i == '0);
      big_q  <= (n_cl > SZ_N_W'(MIN_BLOCK_LOG2) + SZ_N_W'(top));
      bad_q  <= off_bad;
      n_q    <= n_cl[LOG2_W-1:0];
      need_q <= ORD_W'(n_cl - SZ_N_W'(MIN_BLOCK_LOG2));
      u_q    <= (command_i == CMD_FREE) ? off_u : '0;
    end
    if (cmd_i.scan_adv) begin
      u_q <= u_next[UNIT_W-1:0];
    end
    if (cmd_i.ord_ld) begin
      ord_q <= e_ord;
    end
    if (cmd_i.split) begin
      ord_q <= ord_q - ORD_W'(1);
    end
    if (cmd_i.merge) begin
      u_q   <= u_q & ~obit;
      ord_q <= ord_q + ORD_W'(1);
    end
    if (cmd_i.take) begin
      res_status_q <= ST_OK;
      res_addr_q   <= base_q + (ADDR_W'(u_q) << MIN_BLOCK_LOG2);
      res_log2_q   <= n_q;
    end
    if (cmd_i.fset) begin
      res_status_q <= ST_OK;
      res_addr_q   <= '0;
      res_log2_q   <= '0;
    end
    if (cmd_i.fail) begin
      res_status_q <= (!cmd_q && zero_q) ? ST_ZERO : ST_FAIL;
      res_addr_q   <= '0;
      res_log2_q   <= '0;
    end
    if (cmd_i.publish) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_log2_q   <= res_log2_q;
    end
  end

  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;
  assign granted_log2_o    = out_log2_q;

endmodule

[rtl/bba_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: table clear sweep, allocate scan and split, free merge, and
// output beat handshake.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 region_wr_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bba_pkg::dp_status_t  sts_i,
  output bba_pkg::ctrl_cmd_t   cmd_o
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_A_CHK,
    S_A_SPLIT,
    S_F_CHK,
    S_B_RD,
    S_B_CHK,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_U;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.pre_fail) begin
          cmd_o.fail = 1'b1;
          state_d    = S_FINISH;
        end else begin
          state_d = sts_i.cmd_free ? S_F_CHK : S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts_i.ent_match) begin
          cmd_o.ord_ld = 1'b1;
          state_d      = S_A_SPLIT;
        end else if (sts_i.scan_end) begin
          cmd_o.fail = 1'b1;
          state_d    = S_FINISH;
        end else begin
          cmd_o.scan_adv = 1'b1;
          cmd_o.rd_sel   = RD_NEXT;
        end
      end
      S_A_SPLIT: begin
        if (sts_i.split_more) begin
          cmd_o.split = 1'b1;
        end else begin
          cmd_o.take = 1'b1;
          state_d    = S_FINISH;
        end
      end
      S_F_CHK: begin
        if (sts_i.ent_alloc) begin
          cmd_o.ord_ld = 1'b1;
          state_d      = S_B_RD;
        end else begin
          cmd_o.fail = 1'b1;
          state_d    = S_FINISH;
        end
      end
      S_B_RD: begin
        if (sts_i.merge_more) begin
          cmd_o.rd_sel = RD_BUDDY;
          state_d      = S_B_CHK;
        end else begin
          cmd_o.fset = 1'b1;
          state_d    = S_FINISH;
        end
      end
      S_B_CHK: begin
        if (sts_i.buddy_ok) begin
          cmd_o.merge = 1'b1;
          state_d     = S_B_RD;
        end else begin
          cmd_o.fset = 1'b1;
          state_d    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Region change restarts the clear sweep
    if (region_wr_i) begin
      cmd_o.clr_start = 1'b1;
      cmd_o.clr_step  = 1'b0;
      state_d         = S_CLEAR;
    end
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/buddy_block_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a power-of-two region of 4 KiB units (at most 1024 units).
// ----------------------------------------------------------------------------
// After reset, and after every write of region_log2, the block sweeps its
// 1024-entry unit table with in_ready_o low, leaving one free block that
// covers the region. One request is handled at a time; the table is a
// single-port-read memory with registered data, which sets the pace. An
// allocate walks blocks in address order until the first fit (at most 1024
// blocks) and then halves that block as needed; a free checks its block and
// then merges with each free buddy in turn. A finished result sits in an
// output register, so the next request is taken while it waits.
module buddy_block_allocator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bba_pkg::ADDR_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [bba_pkg::SIZE_W-1:0]     request_size_i,
  input  logic [bba_pkg::ADDR_W-1:0]     block_address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [bba_pkg::ADDR_W-1:0]     granted_address_o,
  output logic [bba_pkg::LOG2_W-1:0]     granted_log2_o
);
  import bba_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       region_wr;

  assign region_wr = cfg_we_i && (cfg_idx_i == CFG_REGION);

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .region_wr_i (region_wr),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bba_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (command_i),
    .request_size_i    (request_size_i),
    .block_address_i   (block_address_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .granted_log2_o    (granted_log2_o)
  );

endmodule

[rtl/bba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [bba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [1:0]                     status_o,
  input logic [bba_pkg::ADDR_W-1:0]     granted_address_o,
  input logic [bba_pkg::LOG2_W-1:0]     granted_log2_o
);
  import bba_pkg::*;

  // A pending result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_address_o))
    else $error("output beat dropped or changed while stalled");

  // One request at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a request is in flight");

  // Failures carry no grant
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (granted_address_o == '0)
      && (granted_log2_o == '0))
    else $error("non-success result carries a grant");

  // Grants are at least one unit; free success reports zero size
  a_grant_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> (granted_log2_o == '0)
      || (granted_log2_o >= LOG2_W'(MIN_BLOCK_LOG2)))
    else $error("grant smaller than one unit");

  // Region change starts the clear sweep
  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_REGION) |=> !in_ready_o)
    else $error("input ready during table clear");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cfg_we_i          (cfg_we_i),
  .cfg_idx_i         (cfg_idx_i),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .granted_address_o (granted_address_o),
  .granted_log2_o    (granted_log2_o)
);
